// File: sv/nearest_segment_within_radius_macros.svh
// Assertion helpers shared by the RTL of the nearest segment search.
`ifndef NEAREST_SEGMENT_WITHIN_RADIUS_MACROS_SVH
`define NEAREST_SEGMENT_WITHIN_RADIUS_MACROS_SVH

// Implication or plain property, checked out of reset.
`define NSR_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen out of reset.
`define NSR_NEVER(name, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

// File: sv/nsr_pkg.sv
// ----------------------------------------------------------------------------
// nsr_pkg
// Shared constants and types of the nearest segment search.
// ----------------------------------------------------------------------------
package nsr_pkg;

	localparam int MAX_SEGMENTS_DEF = 64;
	localparam int COORD_BITS_DEF   = 16;
	localparam int RAD_BITS         = 16;
	localparam int COUNT_BITS       = 7;
	localparam int SLOT_BITS        = 6;
	localparam int FIELD_BITS       = 16;

	// Control of one multiply-accumulate operation.
	typedef struct packed {
		logic en;   // operation issued this cycle
		logic clr;  // start a new sum with this product
		logic neg;  // subtract the product
		logic hi;   // product weighs one limb higher
	} mac_ctl_t;

endpackage

// File: sv/nsr_ram.sv
// ----------------------------------------------------------------------------
// nsr_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module nsr_ram #(
	parameter int W     = 48,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: sv/nsr_mac.sv
// ----------------------------------------------------------------------------
// nsr_mac
// Shared signed multiplier with a registered product and a wide accumulator.
// ----------------------------------------------------------------------------
module nsr_mac
	import nsr_pkg::*;
#(
	parameter int OPW  = 35,
	parameter int ACCW = 3 * OPW - 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mac_ctl_t               ctl,
	input  logic signed [OPW-1:0]  op_a,
	input  logic signed [OPW-1:0]  op_b,
	output logic signed [ACCW-1:0] acc
);

	logic signed [2*OPW-1:0] prod_s1;
	mac_ctl_t                ctl_s1;
	logic signed [ACCW-1:0]  acc_q;
	logic signed [ACCW-1:0]  term;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= op_a * op_b;
	end

	always_comb begin
		term = ACCW'(prod_s1);
		if (ctl_s1.hi) begin
			term = term <<< (OPW - 1);
		end
		if (ctl_s1.neg) begin
			term = -term;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.en) begin
			acc_q <= ctl_s1.clr ? term : acc_q + term;
		end
	end

	assign acc = acc_q;

endmodule

// File: sv/nearest_segment_within_radius.sv
// ----------------------------------------------------------------------------
// nearest_segment_within_radius
// Nearest stored 3D segment line to a query point, within a radius.
// ----------------------------------------------------------------------------
// A load transfer writes one segment slot. A query transfer scans slots 0
// to segment_count-1, at most MAX_SEGMENTS of them, and returns one result:
// it squares the radius in setup, runs the products of each scanned slot and
// hands the result to the output register. The single shared multiplier
// performs the 19 products of each slot one after another. The input is
// stalled while a query runs; the result register lets a new transfer in
// while the last result waits.
`include "nearest_segment_within_radius_macros.svh"

module nearest_segment_within_radius
	import nsr_pkg::*;
#(
	parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
	parameter int COORD_BITS   = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [COUNT_BITS-1:0]        cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         command,
	input  logic [SLOT_BITS-1:0]         slot,
	input  logic signed [FIELD_BITS-1:0] start_x,
	input  logic signed [FIELD_BITS-1:0] start_y,
	input  logic signed [FIELD_BITS-1:0] start_z,
	input  logic signed [FIELD_BITS-1:0] end_x,
	input  logic signed [FIELD_BITS-1:0] end_y,
	input  logic signed [FIELD_BITS-1:0] end_z,
	input  logic signed [FIELD_BITS-1:0] query_x,
	input  logic signed [FIELD_BITS-1:0] query_y,
	input  logic signed [FIELD_BITS-1:0] query_z,
	input  logic [RAD_BITS-1:0]          search_radius,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic                         found,
	output logic [SLOT_BITS-1:0]         nearest_index
);

	localparam int K    = COORD_BITS;
	localparam int OPW  = (2 * K + 3 > 2 * RAD_BITS + 1) ? 2 * K + 3 : 2 * RAD_BITS + 1;
	localparam int LW   = OPW - 1;
	localparam int ACCW = 3 * OPW - 1;
	localparam int AW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int CW   = $clog2(MAX_SEGMENTS + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_PRE  = 2'd1;
	localparam logic [1:0] ST_SEG  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	localparam logic [4:0] S_READ   = 5'd0;
	localparam logic [4:0] S_DIFF   = 5'd1;
	localparam logic [4:0] S_X0A    = 5'd2;
	localparam logic [4:0] S_X0B    = 5'd3;
	localparam logic [4:0] S_X1A    = 5'd4;
	localparam logic [4:0] S_X1B    = 5'd5;
	localparam logic [4:0] S_X2A    = 5'd6;
	localparam logic [4:0] S_X2B    = 5'd7;
	localparam logic [4:0] S_SQ0    = 5'd8;
	localparam logic [4:0] S_SQ1    = 5'd9;
	localparam logic [4:0] S_SQ2    = 5'd10;
	localparam logic [4:0] S_LN0    = 5'd11;
	localparam logic [4:0] S_LN1    = 5'd12;
	localparam logic [4:0] S_LN2    = 5'd13;
	localparam logic [4:0] S_WAIT   = 5'd14;
	localparam logic [4:0] S_LCAP   = 5'd15;
	localparam logic [4:0] S_RL     = 5'd16;
	localparam logic [4:0] S_CLO    = 5'd17;
	localparam logic [4:0] S_CHI    = 5'd18;
	localparam logic [4:0] S_B0     = 5'd19;
	localparam logic [4:0] S_B1     = 5'd20;
	localparam logic [4:0] S_B2     = 5'd21;
	localparam logic [4:0] S_B3     = 5'd22;
	localparam logic [4:0] S_WAIT2  = 5'd23;
	localparam logic [4:0] S_DECIDE = 5'd24;
	localparam logic [4:0] S_PISSUE = 5'd0;
	localparam logic [4:0] S_PCAP   = 5'd2;

	logic [1:0]            state_q;
	logic [4:0]            step_q;
	logic [COUNT_BITS-1:0] seg_count_q;
	logic [CW-1:0]         n_q;
	logic [CW-1:0]         i_q;
	logic                  out_valid_q;
	logic                  found_q;
	logic [SLOT_BITS-1:0]  index_q;
	logic                  bfound_q;
	logic                  qual_q;

	logic signed [K-1:0]   p_q [3];
	logic [RAD_BITS-1:0]   rad_q;
	logic [LW-1:0]         r2_q;
	logic signed [K:0]     u_q [3];
	logic signed [K:0]     v_q [3];
	logic signed [K:0]     d_q [3];
	logic signed [OPW-1:0] c_q [3];
	logic [2*LW-1:0]       cc_q;
	logic [LW-1:0]         l_q;
	logic [2*LW-1:0]       bc_q;
	logic [LW-1:0]         bl_q;
	logic [AW-1:0]         bidx_q;

	logic                  in_xfer;
	logic                  out_xfer;
	logic                  res_load;
	logic                  load_we;
	logic [3*K-1:0]        wr_start;
	logic [3*K-1:0]        wr_end;
	logic [3*K-1:0]        rd_start;
	logic [3*K-1:0]        rd_end;
	logic signed [K-1:0]   a_c [3];
	logic signed [K-1:0]   b_c [3];

	mac_ctl_t               ctl;
	logic signed [OPW-1:0]  op_a;
	logic signed [OPW-1:0]  op_b;
	logic signed [ACCW-1:0] acc;
	logic signed [OPW-1:0]  cc_lo;
	logic signed [OPW-1:0]  cc_hi;
	logic signed [OPW-1:0]  bc_lo;
	logic signed [OPW-1:0]  bc_hi;
	logic signed [OPW-1:0]  l_op;
	logic signed [OPW-1:0]  bl_op;
	logic                   acc_neg;
	logic                   better;
	logic                   take;
	logic                   last_seg;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign res_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;
	assign found     = found_q;
	assign nearest_index = index_q;

	// Loads beyond the table are dropped.
	assign load_we  = in_xfer && !command && (32'(slot) < MAX_SEGMENTS);
	assign wr_start = {K'(start_z), K'(start_y), K'(start_x)};
	assign wr_end   = {K'(end_z), K'(end_y), K'(end_x)};

	nsr_ram #(.W(3 * K), .DEPTH(MAX_SEGMENTS), .AW(AW)) u_start_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(slot)),
		.wdata (wr_start),
		.raddr (i_q[AW-1:0]),
		.rdata (rd_start)
	);

	nsr_ram #(.W(3 * K), .DEPTH(MAX_SEGMENTS), .AW(AW)) u_end_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(slot)),
		.wdata (wr_end),
		.raddr (i_q[AW-1:0]),
		.rdata (rd_end)
	);

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			a_c[k] = rd_start[k*K +: K];
			b_c[k] = rd_end[k*K +: K];
		end
	end

	assign cc_lo = $signed({1'b0, cc_q[LW-1:0]});
	assign cc_hi = $signed({1'b0, cc_q[2*LW-1:LW]});
	assign bc_lo = $signed({1'b0, bc_q[LW-1:0]});
	assign bc_hi = $signed({1'b0, bc_q[2*LW-1:LW]});
	assign l_op  = $signed({1'b0, l_q});
	assign bl_op = $signed({1'b0, bl_q});

	// Micro-program of the shared multiplier.
	always_comb begin
		ctl  = '0;
		op_a = '0;
		op_b = '0;
		if (state_q == ST_PRE && step_q == S_PISSUE) begin
			ctl  = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
			op_a = $signed(OPW'(rad_q));
			op_b = $signed(OPW'(rad_q));
		end else if (state_q == ST_SEG) begin
			case (step_q)
				S_X0A: begin
					ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
					op_a = OPW'(u_q[1]); op_b = OPW'(v_q[2]);
				end
				S_X0B: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
					op_a = OPW'(u_q[2]); op_b = OPW'(v_q[1]);
				end
				S_X1A: begin
					ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
					op_a = OPW'(u_q[2]); op_b = OPW'(v_q[0]);
				end
				S_X1B: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
					op_a = OPW'(u_q[0]); op_b = OPW'(v_q[2]);
				end
				S_X2A: begin
					ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
					op_a = OPW'(u_q[0]); op_b = OPW'(v_q[1]);
				end
				S_X2B: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
					op_a = OPW'(u_q[1]); op_b = OPW'(v_q[0]);
				end
				S_SQ0: begin
					ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
					op_a = c_q[0]; op_b = c_q[0];
				end
				S_SQ1: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b0};
					op_a = c_q[1]; op_b = c_q[1];
				end
				S_SQ2: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b0};
					op_a = c_q[2]; op_b = c_q[2];
				end
				S_LN0: begin
					ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
					op_a = OPW'(d_q[0]); op_b = OPW'(d_q[0]);
				end
				S_LN1: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b0};
					op_a = OPW'(d_q[1]); op_b = OPW'(d_q[1]);
				end
				S_LN2: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b0};
					op_a = OPW'(d_q[2]); op_b = OPW'(d_q[2]);
				end
				S_RL: begin
					ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
					op_a = $signed({1'b0, r2_q}); op_b = l_op;
				end
				S_CLO: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
					op_a = cc_lo; op_b = OPW'(1);
				end
				S_CHI: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b1};
					op_a = cc_hi; op_b = OPW'(1);
				end
				S_B0: begin
					ctl = '{en: 1'b1, clr: 1'b1, neg: 1'b0, hi: 1'b0};
					op_a = bc_lo; op_b = l_op;
				end
				S_B1: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b0, hi: 1'b1};
					op_a = bc_hi; op_b = l_op;
				end
				S_B2: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b0};
					op_a = cc_lo; op_b = bl_op;
				end
				S_B3: begin
					ctl = '{en: 1'b1, clr: 1'b0, neg: 1'b1, hi: 1'b1};
					op_a = cc_hi; op_b = bl_op;
				end
				default: begin
					ctl = '0;
				end
			endcase
		end
	end

	nsr_mac #(.OPW(OPW), .ACCW(ACCW)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.op_a   (op_a),
		.op_b   (op_b),
		.acc    (acc)
	);

	// At the decision step the sum holds best_c * L - C * best_l.
	assign acc_neg  = acc[ACCW-1];
	assign better   = !acc_neg && (acc != '0);
	assign take     = qual_q && (!bfound_q || better);
	assign last_seg = ((i_q + CW'(1)) == n_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			seg_count_q <= '0;
			n_q         <= '0;
			i_q         <= '0;
			out_valid_q <= 1'b0;
			found_q     <= 1'b0;
			index_q     <= '0;
			bfound_q    <= 1'b0;
			qual_q      <= 1'b0;
		end else begin
			if (cfg_we) begin
				seg_count_q <= cfg_wdata;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_xfer) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_xfer && command) begin
						state_q  <= ST_PRE;
						step_q   <= S_PISSUE;
						i_q      <= '0;
						bfound_q <= 1'b0;
						n_q      <= (32'(seg_count_q) > MAX_SEGMENTS) ?
						            CW'(MAX_SEGMENTS) : CW'(seg_count_q);
					end
				end
				ST_PRE: begin
					if (step_q == S_PCAP) begin
						step_q  <= S_READ;
						state_q <= (n_q == '0) ? ST_DONE : ST_SEG;
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_SEG: begin
					if (step_q == S_B1) begin
						qual_q <= (l_q != '0) && !acc_neg;
					end
					if (step_q == S_DECIDE) begin
						if (take) begin
							bfound_q <= 1'b1;
						end
						step_q <= S_READ;
						if (last_seg) begin
							state_q <= ST_DONE;
						end else begin
							i_q <= i_q + CW'(1);
						end
					end else begin
						step_q <= step_q + 5'd1;
					end
				end
				ST_DONE: begin
					if (res_load) begin
						found_q     <= bfound_q;
						index_q     <= bfound_q ? SLOT_BITS'(bidx_q) : '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer && command) begin
			p_q[0] <= K'(query_x);
			p_q[1] <= K'(query_y);
			p_q[2] <= K'(query_z);
			rad_q  <= search_radius;
		end
		if (state_q == ST_PRE && step_q == S_PCAP) begin
			r2_q <= acc[LW-1:0];
		end
		if (state_q == ST_SEG) begin
			case (step_q)
				S_DIFF: begin
					for (int k = 0; k < 3; k++) begin
						u_q[k] <= (K+1)'(p_q[k]) - (K+1)'(a_c[k]);
						v_q[k] <= (K+1)'(p_q[k]) - (K+1)'(b_c[k]);
						d_q[k] <= (K+1)'(b_c[k]) - (K+1)'(a_c[k]);
					end
				end
				S_X1B:    c_q[0] <= $signed(acc[OPW-1:0]);
				S_X2B:    c_q[1] <= $signed(acc[OPW-1:0]);
				S_SQ1:    c_q[2] <= $signed(acc[OPW-1:0]);
				S_LN1:    cc_q   <= acc[2*LW-1:0];
				S_LCAP:   l_q    <= acc[LW-1:0];
				S_DECIDE: begin
					if (take) begin
						bidx_q <= i_q[AW-1:0];
						bc_q   <= cc_q;
						bl_q   <= l_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`NSR_ASSERT(a_out_from_done, $rose(out_valid_q) |-> $past(state_q) == ST_DONE, "stray result")
	`NSR_NEVER(a_scan_in_range, state_q == ST_SEG && i_q >= n_q, "scan index beyond segment count")
	`NSR_NEVER(a_notfound_zero, out_valid_q && !found_q && index_q != '0, "index set without a match")
	`NSR_ASSERT(a_query_busy, in_xfer && command |=> in_stall, "query transfer did not start a scan")

endmodule
